[rtl/rdq_pkg.sv]
// Shared constants, types and helpers for the reversible byte deque.
// Depends on nothing; used by rdq_store, rdq_ctrl and reversible_deque.
package rdq_pkg;

  // Number of entries in the circular byte store.
  localparam int unsigned DEPTH = 1024;
  // Physical index width and fill-count width (must hold DEPTH itself).
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  // Fixed widths of the transaction fields.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 11;

  // Width used to compare a requested position against the fill count.
  localparam int unsigned CMP_W = (FW > POS_W) ? FW : POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_REVERSE    = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_PUSH_BACK  = 2'd2,
    KIND_READ       = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_POS   = 2'd2,
    STAT_UNUSED    = 2'd3
  } status_t;

  // One access to the byte store: a write or a read, never both.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     addr;
    logic [CHAR_W-1:0] wdata;
  } mem_req_t;

  // Add two physical indexes modulo DEPTH; both inputs are below DEPTH.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] sum;
    logic [AW:0] lim;
    lim = (AW+1)'(DEPTH);
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= lim) begin
      sum = sum - lim;
    end
    return sum[AW-1:0];
  endfunction

endpackage

[rtl/reversible_deque.sv]
// Reversible byte deque: top level. Depends on rdq_pkg, rdq_ctrl, rdq_store.
// done is high in the cycle after the accepting edge, and the result is taken at
// the edge that ends that cycle. The receiver cannot stall.
// Throughput: one transaction per cycle; busy stays low, since every
// transaction makes at most one access to the one-port store.
// Reset (rst, synchronous, active high) empties the deque and clears the
// reversal flag; the store contents are left as they are.
module reversible_deque (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rdq_pkg::KIND_W-1:0]   kind,
  input  logic [rdq_pkg::CHAR_W-1:0]   char_in,
  input  logic [rdq_pkg::POS_W-1:0]    position,
  output logic                         done,
  output logic [rdq_pkg::CHAR_W-1:0]   data_out,
  output logic [rdq_pkg::STAT_W-1:0]   status,
  output logic [rdq_pkg::LEN_W-1:0]    length
);

  logic                        accept;
  rdq_pkg::mem_req_t           req;
  rdq_pkg::status_t            status_now;
  logic [rdq_pkg::FW-1:0]      fill_now;
  logic [rdq_pkg::CHAR_W-1:0]  rdata;

  // Result registers. The read data comes straight from the store's output
  // register, which only loads on a successful read, so it stays valid for
  // the whole result cycle even while the next transaction is being taken.
  rdq_pkg::status_t            status_q;
  logic [rdq_pkg::LEN_W-1:0]   length_q;
  logic                        read_ok;

  // Every transaction touches the store at most once and finishes its
  // bookkeeping in the accepting cycle, so there is never a reason to stall.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (rdq_pkg::kind_t'(kind)),
    .char_in    (char_in),
    .position   (position),
    .req        (req),
    .status_now (status_now),
    .fill_now   (fill_now)
  );

  rdq_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Payload of the result; no reset needed since done qualifies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_now;
      length_q <= rdq_pkg::LEN_W'(fill_now);
      read_ok  <= req.rd_en;
    end
  end

  // Anything other than a successful read reports a zero byte.
  assign data_out = read_ok ? rdata : '0;
  assign status   = status_q;
  assign length   = length_q;

endmodule

[rtl/rdq_store.sv]
// Single-port circular byte store with a registered read port.
// Depends on rdq_pkg for DEPTH, widths and the mem_req_t access record.
module rdq_store (
  input  logic                          clk,
  input  rdq_pkg::mem_req_t             req,
  output logic [rdq_pkg::CHAR_W-1:0]    rdata
);

  logic [rdq_pkg::CHAR_W-1:0] mem [rdq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Read data holds until the next read, so it may be shown later than the read itself.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[rtl/rdq_ctrl.sv]
// Pointer, fill count and reversal flag of the deque, plus the store access
// and the status for each transaction. Depends on rdq_pkg.
module rdq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  rdq_pkg::kind_t               kind,
  input  logic [rdq_pkg::CHAR_W-1:0]   char_in,
  input  logic [rdq_pkg::POS_W-1:0]    position,
  output rdq_pkg::mem_req_t            req,
  output rdq_pkg::status_t             status_now,
  output logic [rdq_pkg::FW-1:0]       fill_now
);

  logic [rdq_pkg::AW-1:0] head;
  logic [rdq_pkg::AW-1:0] head_next;
  logic [rdq_pkg::FW-1:0] fill;
  logic [rdq_pkg::FW-1:0] fill_next;
  logic                   rev;
  logic                   rev_next;

  logic                   full;
  logic                   phys_back;
  logic [rdq_pkg::AW-1:0] head_dec;
  logic [rdq_pkg::AW-1:0] off;
  logic [rdq_pkg::CMP_W-1:0] pos_ext;
  logic [rdq_pkg::CMP_W-1:0] fill_ext;
  logic [rdq_pkg::FW-1:0]    rev_off;

  assign full     = (fill == rdq_pkg::FW'(rdq_pkg::DEPTH));
  assign head_dec = (head == '0) ? rdq_pkg::AW'(rdq_pkg::DEPTH - 1) : head - 1'b1;
  assign pos_ext  = rdq_pkg::CMP_W'(position);
  assign fill_ext = rdq_pkg::CMP_W'(fill);
  // Only meaningful when position is below fill, so it stays below DEPTH.
  assign rev_off  = fill - 1'b1 - rdq_pkg::FW'(position);
  assign off      = rev ? rev_off[rdq_pkg::AW-1:0] : rdq_pkg::AW'(position);

  always_comb begin
    head_next  = head;
    fill_next  = fill;
    rev_next   = rev;
    status_now = rdq_pkg::STAT_OK;
    phys_back  = 1'b0;
    req.wr_en  = 1'b0;
    req.rd_en  = 1'b0;
    req.addr   = head;
    req.wdata  = char_in;
    case (kind)
      rdq_pkg::KIND_REVERSE: begin
        rev_next = ~rev;
      end
      rdq_pkg::KIND_PUSH_FRONT, rdq_pkg::KIND_PUSH_BACK: begin
        // A logical front push lands at the physical back while reversed.
        phys_back = (kind == rdq_pkg::KIND_PUSH_BACK) ? ~rev : rev;
        if (full) begin
          status_now = rdq_pkg::STAT_FULL;
        end else begin
          req.wr_en = accept;
          fill_next = fill + 1'b1;
          if (phys_back) begin
            req.addr = rdq_pkg::wrap_add(head, fill[rdq_pkg::AW-1:0]);
          end else begin
            req.addr  = head_dec;
            head_next = head_dec;
          end
        end
      end
      rdq_pkg::KIND_READ: begin
        if (pos_ext >= fill_ext) begin
          status_now = rdq_pkg::STAT_BAD_POS;
        end else begin
          req.rd_en = accept;
          req.addr  = rdq_pkg::wrap_add(head, off);
        end
      end
      default: begin
        status_now = rdq_pkg::STAT_OK;
      end
    endcase
    fill_now = fill_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      rev  <= 1'b0;
    end else if (accept) begin
      head <= head_next;
      fill <= fill_next;
      rev  <= rev_next;
    end
  end

endmodule

[tb/tb_reversible_deque.sv]
// Self-checking testbench for the reversible byte deque (reversible_deque).
// Depends on rdq_pkg for the transaction field widths, kind codes and status codes.
// A directed table runs first, then a random fill to capacity and a random run at full.
module tb_reversible_deque;
  timeunit 1ns;
  timeprecision 1ps;

  import rdq_pkg::*;

  // One expected result transaction: the byte read, the status and the length afterwards.
  typedef struct packed {
    logic [CHAR_W-1:0] data;
    status_t           stat;
    logic [LEN_W-1:0]  len;
  } deque_result_t;

  // One row of the directed table. When typed is set, want holds the expected
  // result written out by hand. Otherwise the mirror below supplies it.
  typedef struct packed {
    kind_t             k;
    logic [CHAR_W-1:0] c;
    logic [POS_W-1:0]  p;
    bit                typed;
    deque_result_t     want;
  } dir_row_t;

  localparam int N_DIR = 25;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // Empty deque: every read fails, whatever the position.
    '{KIND_READ,       8'h00, 10'd0,    1'b1, '{8'h00, STAT_BAD_POS, 11'd0}},
    '{KIND_READ,       8'hFF, 10'd1023, 1'b1, '{8'h00, STAT_BAD_POS, 11'd0}},
    // Reversing an empty deque is legal, and reads still fail while reversed.
    '{KIND_REVERSE,    8'h00, 10'd0,    1'b1, '{8'h00, STAT_OK,      11'd0}},
    '{KIND_READ,       8'h00, 10'd0,    1'b1, '{8'h00, STAT_BAD_POS, 11'd0}},
    '{KIND_REVERSE,    8'hFF, 10'd1023, 1'b1, '{8'h00, STAT_OK,      11'd0}},
    // Extreme bytes at the back, then a front push that wraps the head pointer.
    '{KIND_PUSH_BACK,  8'h00, 10'd1023, 1'b1, '{8'h00, STAT_OK,      11'd1}},
    '{KIND_PUSH_BACK,  8'hFF, 10'd0,    1'b1, '{8'h00, STAT_OK,      11'd2}},
    '{KIND_PUSH_FRONT, 8'hA5, 10'd512,  1'b1, '{8'h00, STAT_OK,      11'd3}},
    // The logical order is now A5 00 FF.
    '{KIND_READ,       8'hFF, 10'd0,    1'b1, '{8'hA5, STAT_OK,      11'd3}},
    '{KIND_READ,       8'h00, 10'd1,    1'b1, '{8'h00, STAT_OK,      11'd3}},
    '{KIND_READ,       8'h00, 10'd2,    1'b1, '{8'hFF, STAT_OK,      11'd3}},
    '{KIND_READ,       8'h00, 10'd3,    1'b1, '{8'h00, STAT_BAD_POS, 11'd3}},
    // Once reversed, reads count from the tail: FF 00 A5.
    '{KIND_REVERSE,    8'h00, 10'd0,    1'b1, '{8'h00, STAT_OK,      11'd3}},
    '{KIND_READ,       8'h00, 10'd0,    1'b1, '{8'hFF, STAT_OK,      11'd3}},
    '{KIND_READ,       8'h00, 10'd2,    1'b1, '{8'hA5, STAT_OK,      11'd3}},
    // While reversed, pushes land at the opposite physical end.
    '{KIND_PUSH_FRONT, 8'h5A, 10'd0,    1'b0, '0},
    '{KIND_PUSH_BACK,  8'h3C, 10'd0,    1'b0, '0},
    '{KIND_READ,       8'h00, 10'd0,    1'b0, '0},
    '{KIND_READ,       8'h00, 10'd1,    1'b0, '0},
    '{KIND_READ,       8'h00, 10'd2,    1'b0, '0},
    '{KIND_READ,       8'h00, 10'd3,    1'b0, '0},
    '{KIND_READ,       8'h00, 10'd4,    1'b0, '0},
    '{KIND_REVERSE,    8'h00, 10'd0,    1'b0, '0},
    '{KIND_READ,       8'h00, 10'd0,    1'b0, '0},
    '{KIND_READ,       8'hFF, 10'd1023, 1'b1, '{8'h00, STAT_BAD_POS, 11'd5}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input starts at a known value. The stimulus is driven at the falling edge.
  logic              start    = 1'b0;
  logic [KIND_W-1:0] kind     = '0;
  logic [CHAR_W-1:0] char_in  = '0;
  logic [POS_W-1:0]  position = '0;

  logic              busy;
  logic              done;
  logic [CHAR_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  length;

  // The testbench keeps its own mirror of the deque. It holds the physical bytes,
  // the head index, the number of bytes held and the reversal flag.
  logic [CHAR_W-1:0] mirror_bytes [DEPTH];
  int                mirror_head    = 0;
  int                mirror_held    = 0;
  bit                mirror_flipped = 1'b0;

  // Results that are still due, oldest first.
  deque_result_t pending_results [$];
  int            sent_count = 0;
  bit            failed     = 1'b0;

  reversible_deque u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .char_in  (char_in),
    .position (position),
    .done     (done),
    .data_out (data_out),
    .status   (status),
    .length   (length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one accepted transaction to the mirror and returns its result.
  // A logical push goes to the physical back exactly when "push back" and
  // "reversed" disagree. Otherwise the head steps down one slot, modulo DEPTH,
  // and the byte is written there.
  function automatic deque_result_t deque_apply(input kind_t k, input logic [CHAR_W-1:0] c,
                                                input logic [POS_W-1:0] p);
    deque_result_t r;
    int            offset;
    r.data = '0;
    r.stat = STAT_OK;
    case (k)
      KIND_REVERSE: begin
        mirror_flipped = !mirror_flipped;
      end
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (mirror_held >= DEPTH) begin
          // A full store drops the byte and leaves everything else untouched.
          r.stat = STAT_FULL;
        end else if ((k == KIND_PUSH_BACK) != mirror_flipped) begin
          mirror_bytes[(mirror_head + mirror_held) % DEPTH] = c;
          mirror_held++;
        end else begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_bytes[mirror_head] = c;
          mirror_held++;
        end
      end
      KIND_READ: begin
        if (int'(p) >= mirror_held) begin
          r.stat = STAT_BAD_POS;
        end else begin
          // While reversed, logical position 0 is the physical tail.
          offset = mirror_flipped ? (mirror_held - 1 - int'(p)) : int'(p);
          r.data = mirror_bytes[(mirror_head + offset) % DEPTH];
        end
      end
      default: begin
      end
    endcase
    r.len = LEN_W'(mirror_held);
    return r;
  endfunction

  // Drives one command transaction. The task is entered at a falling edge. It may
  // first leave start low and wait for the next falling edge. It then holds the command until it is
  // accepted at a rising edge with busy low, and returns at the next falling edge.
  // Between items that follow each other directly, start is assigned only once
  // per time step.
  task automatic issue(input kind_t k, input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] p,
                       input bit typed, input deque_result_t typed_want);
    deque_result_t predicted;
    bit            quiet;
    // Idling is switched off over one long stretch of the random run (while sent_count
    // is from 600 to 899), so that back-to-back transactions are exercised there.
    quiet = (sent_count >= 600) && (sent_count < 900);
    if (!quiet && ($urandom_range(0, 99) < 8)) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    kind     <= k;
    char_in  <= c;
    position <= p;
    do @(posedge clk); while (busy !== 1'b0);
    // The mirror is always stepped, so its state stays current even when the
    // table supplies the expected value by hand.
    predicted = deque_apply(k, c, p);
    pending_results = {pending_results, (typed ? typed_want : predicted)};
    sent_count++;
    @(negedge clk);
  endtask

  // Result checker. A strobe on done marks a result that is valid for exactly
  // one cycle, and it is taken at the rising edge that closes that cycle.
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: data_out %0h status %0d length %0d",
               data_out, status, length);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data) begin
          $error("data_out mismatch: expected %0h, actual %0h", want.data, data_out);
          failed = 1'b1;
        end
        if (status !== want.stat) begin
          $error("status mismatch: expected %0d, actual %0d", want.stat, status);
          failed = 1'b1;
        end
        if (length !== want.len) begin
          $error("length mismatch: expected %0d, actual %0d", want.len, length);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    deque_result_t     none;
    int                pick;
    kind_t             k;
    logic [POS_W-1:0]  p;
    none = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      issue(DIR_ROWS[i].k, DIR_ROWS[i].c, DIR_ROWS[i].p, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // Nothing ever removes a byte, so the fill count only grows. The first random
    // phase leans on pushes, so the store fills up with a mix of front and back
    // pushes, reads and reversals along the way. Reads mostly target positions
    // that are held, and the rest take any position the field can carry.
    while (mirror_held < DEPTH) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end else if (pick < 90) begin
        k = KIND_READ;
      end else begin
        k = KIND_REVERSE;
      end
      if (k == KIND_READ && mirror_held > 0 && $urandom_range(0, 2) != 0) begin
        p = POS_W'($urandom_range(0, mirror_held - 1));
      end else begin
        p = POS_W'($urandom_range(0, 1023));
      end
      issue(k, CHAR_W'($urandom), p, 1'b0, none);
    end

    // With the store full, every push must be dropped and flagged. Every position
    // the field can carry is now a valid read.
    repeat (300) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end else if (pick < 80) begin
        k = KIND_READ;
      end else begin
        k = KIND_REVERSE;
      end
      issue(k, CHAR_W'($urandom), POS_W'($urandom_range(0, 1023)), 1'b0, none);
    end
    start <= 1'b0;

    // Drain the last results, then keep the clock running before finishing, so that
    // any stray strobe is still caught.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: stops the run with a failure long after the slowest legal run would end.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/rdq_pkg.sv
rtl/rdq_store.sv
rtl/rdq_ctrl.sv
rtl/reversible_deque.sv
tb/tb_reversible_deque.sv
